// File: src/delimited_byte_list_parser_defines.svh
// Assertion macros shared by the checker.
`ifndef DELIMITED_BYTE_LIST_PARSER_DEFINES_SVH
`define DELIMITED_BYTE_LIST_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DBLP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DBLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dblp_pkg.sv
`timescale 1ns / 1ps

package dblp_pkg;

    localparam int CHAR_W  = 8;
    localparam int ACC_W   = 10;
    localparam int DCNT_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_BAD_CHAR        = 3'd1,
        ST_TOO_MANY_DIGITS = 3'd2,
        ST_EMPTY           = 3'd3,
        ST_TOO_MANY_FIELDS = 3'd4,
        ST_TOO_FEW_FIELDS  = 3'd5,
        ST_OVER            = 3'd6
    } t_status;

    // Radix mode codes; the unused code behaves as decimal
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    // Register reset values
    localparam logic [CHAR_W-1:0] DELIM_RST = 8'd44;
    localparam logic [1:0]        RADIX_RST = RADIX_DEC;
    localparam logic [CHAR_W-1:0] COUNT_RST = 8'd1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_1   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_9   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF_ = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF  = 8'h46;

    localparam logic [ACC_W-1:0] BYTE_MAX = 10'd255;

endpackage

// File: src/delimited_byte_list_parser.sv
`timescale 1ns / 1ps

// Delimited byte list parser. Takes one character per transaction and parses a
// list of byte fields split by the configured delimiter and ended by NUL or
// newline. Fields are one binary digit, up to three decimal digits (at most
// 255) or up to two hex digits of either case, as the radix mode selects. Each
// delimiter yields one result with the field value; the terminator yields the
// last field with list end set and a status, and the list state clears. On any
// error the rest of the list up to the terminator is swallowed and the first
// error is reported there with a value of zero; drop the list when status is
// nonzero. Rate: one character per clock sustained unless output stalls, set
// by a single input register feeding a single result register, which loads
// the staged character's result. Characters that make no result never wait
// on the output side. Write configuration only while the block is idle.
module delimited_byte_list_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [dblp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dblp_pkg::CHAR_W-1:0]   i_cfg_data,
    // character input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dblp_pkg::CHAR_W-1:0]   i_char_code,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_byte_value,
    output logic [7:0]                    o_field_index,
    output logic                          o_list_end,
    output logic [2:0]                    o_status
);
    import dblp_pkg::*;

    // configuration
    logic [CHAR_W-1:0] r_delim;
    logic [1:0]        r_radix;
    logic [CHAR_W-1:0] r_count;

    // input stage
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;

    // list state
    logic [ACC_W-1:0]  r_acc,    n_acc;
    logic [DCNT_W-1:0] r_dcnt,   n_dcnt;
    logic [7:0]        r_fdone,  n_fdone;
    t_status           r_err,    n_err;

    // result register
    logic              r_out_valid;
    logic [7:0]        r_out_value;
    logic [7:0]        r_out_index;
    logic              r_out_last;
    t_status           r_out_status;

    // per-character decode
    logic              term;
    logic              is_dig;
    logic [3:0]        dig;
    logic [DCNT_W-1:0] limit;
    logic [ACC_W-1:0]  acc_mac;
    logic [8:0]        total;
    logic              emit;
    logic [7:0]        e_value;
    logic              e_last;
    t_status           e_status;
    logic              consume;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RST;
            r_radix <= RADIX_RST;
            r_count <= COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELIM: r_delim <= i_cfg_data;
                CFG_RADIX: r_radix <= i_cfg_data[1:0];
                CFG_COUNT: r_count <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Digit classification and multiply-add
    // ---------------------------------------------------------------
    always_comb begin
        term   = (r_in_char == CH_NUL) || (r_in_char == CH_LF);
        is_dig = 1'b0;
        dig    = r_in_char[3:0];
        case (r_radix)
            RADIX_BIN: begin
                is_dig  = (r_in_char == CH_0) || (r_in_char == CH_1);
                limit   = 2'd1;
                acc_mac = {r_acc[ACC_W-2:0], 1'b0} + {{(ACC_W-4){1'b0}}, dig};
            end
            RADIX_HEX: begin
                // letters: low nibble 1..6 maps to 10..15
                if (r_in_char inside {[CH_0:CH_9]}) begin
                    is_dig = 1'b1;
                end else if (r_in_char inside {[CH_LA:CH_LF_], [CH_UA:CH_UF]}) begin
                    is_dig = 1'b1;
                    dig    = r_in_char[3:0] + 4'd9;
                end
                limit   = 2'd2;
                acc_mac = {r_acc[ACC_W-5:0], 4'b0000} + {{(ACC_W-4){1'b0}}, dig};
            end
            default: begin
                // decimal, also for the unused mode code
                is_dig  = r_in_char inside {[CH_0:CH_9]};
                limit   = 2'd3;
                acc_mac = {r_acc[ACC_W-4:0], 3'b000} + {r_acc[ACC_W-2:0], 1'b0}
                        + {{(ACC_W-4){1'b0}}, dig};
            end
        endcase
    end

    // ---------------------------------------------------------------
    // List state update and result generation
    // ---------------------------------------------------------------
    always_comb begin
        total    = {1'b0, r_fdone} + 9'd1;
        n_acc    = r_acc;
        n_dcnt   = r_dcnt;
        n_fdone  = r_fdone;
        n_err    = r_err;
        emit     = 1'b0;
        e_value  = r_acc[7:0];
        e_last   = 1'b0;
        e_status = ST_OK;

        if (r_err != ST_OK) begin
            // swallow until terminator, then report first error
            if (term) begin
                emit     = 1'b1;
                e_value  = 8'd0;
                e_last   = 1'b1;
                e_status = r_err;
                n_acc    = '0;
                n_dcnt   = '0;
                n_fdone  = '0;
                n_err    = ST_OK;
            end
        end else if (is_dig) begin
            if (r_dcnt >= limit) begin
                n_err = ST_TOO_MANY_DIGITS;
            end else begin
                n_dcnt = r_dcnt + 2'd1;
                n_acc  = acc_mac;
            end
        end else if (r_in_char == r_delim) begin
            if (r_dcnt == '0) begin
                n_err = ST_EMPTY;
            end else if (r_acc > BYTE_MAX) begin
                n_err = ST_OVER;
            end else if (total >= {1'b0, r_count}) begin
                n_err = ST_TOO_MANY_FIELDS;
            end else begin
                emit    = 1'b1;
                n_fdone = total[7:0];
                n_acc   = '0;
                n_dcnt  = '0;
            end
        end else if (term) begin
            emit   = 1'b1;
            e_last = 1'b1;
            if (r_dcnt == '0) begin
                e_status = ST_EMPTY;
            end else if (r_acc > BYTE_MAX) begin
                e_status = ST_OVER;
            end else if (total < {1'b0, r_count}) begin
                e_status = ST_TOO_FEW_FIELDS;
            end else if (total > {1'b0, r_count}) begin
                e_status = ST_TOO_MANY_FIELDS;
            end
            if (e_status != ST_OK) begin
                e_value = 8'd0;
            end
            n_acc   = '0;
            n_dcnt  = '0;
            n_fdone = '0;
        end else begin
            n_err = ST_BAD_CHAR;
        end
    end

    // A staged character moves on unless it makes a result that cannot land;
    // nothing is taken while in reset
    assign consume    = r_in_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_in_valid || consume);

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_char <= i_char_code;
        end
    end

    // ---------------------------------------------------------------
    // List state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_dcnt  <= '0;
            r_fdone <= '0;
            r_err   <= ST_OK;
        end else if (consume) begin
            r_acc   <= n_acc;
            r_dcnt  <= n_dcnt;
            r_fdone <= n_fdone;
            r_err   <= n_err;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && emit) begin
            r_out_value  <= e_value;
            r_out_index  <= r_fdone;
            r_out_last   <= e_last;
            r_out_status <= e_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_value  = r_out_value;
    assign o_field_index = r_out_index;
    assign o_list_end    = r_out_last;
    assign o_status      = r_out_status;

endmodule

// File: src/dblp_checker.sv
`timescale 1ns / 1ps

`include "delimited_byte_list_parser_defines.svh"

module dblp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [7:0]                     o_byte_value,
    input logic [7:0]                     o_field_index,
    input logic                           o_list_end,
    input logic [2:0]                     o_status
);
    import dblp_pkg::*;

    // stalled result holds
    `DBLP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_byte_value) && $stable(o_field_index) && $stable(o_list_end) && $stable(o_status), "result changed while stalled")

    // only the terminator carries a failure
    `DBLP_ASSERT_SAME(a_mid_ok, i_clk, i_rst_n, o_out_valid && !o_list_end, o_status == ST_OK, "error status on a mid-list result")

    // failed list reports a zero value
    `DBLP_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_byte_value == 8'd0, "nonzero value on a failed list")

    // status code in the defined set
    `DBLP_ASSERT_SAME(a_status_legal, i_clk, i_rst_n, o_out_valid, o_status != 3'd7, "undefined status code")

endmodule

bind delimited_byte_list_parser dblp_checker u_dblp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_byte_value  (o_byte_value),
    .o_field_index (o_field_index),
    .o_list_end    (o_list_end),
    .o_status      (o_status)
);

// File: tb/tb_delimited_byte_list_parser.sv
`timescale 1ns / 1ps

module tb_delimited_byte_list_parser;

    import dblp_pkg::*;

    // Run limits
    localparam int LIMIT_CYCLES  = 500000;
    localparam int SETTLE_CYCLES = 8;      // outlasts the block's input and result registers
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off

    // One parsed field as the block reports it
    typedef struct packed {
        logic [7:0] byte_value;
        logic [7:0] field_index;
        logic       list_end;
        t_status    status;
    } t_parsed_field;

    // DUT signals; the inputs are known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CHAR_W-1:0]    i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [CHAR_W-1:0]    i_char_code = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [7:0]           o_byte_value;
    logic [7:0]           o_field_index;
    logic                 o_list_end;
    logic [2:0]           o_status;

    // Characters waiting to be offered, and fields the parser should emit
    logic [7:0]    char_queue[$];
    t_parsed_field expected_fields[$];
    t_parsed_field head_field;
    int            chars_pushed = 0;
    int            mismatches   = 0;

    // Own copy of the registers
    logic [7:0] cfg_delim = DELIM_RST;
    logic [1:0] cfg_radix = RADIX_RST;
    logic [7:0] cfg_count = COUNT_RST;

    // Own copy of the list state
    logic [9:0] acc       = '0;
    int         ndigits   = 0;
    logic [7:0] nfields   = '0;
    t_status    held_err  = ST_OK;

    // Handshake bookkeeping between processes
    bit char_taken    = 1'b0;   // char transaction at the last rising edge
    int hold_requests = 0;      // raised by the stimulus, served by the receiver
    int holds_served  = 0;
    int tx_gap        = 0;
    int rx_gap        = 0;
    int hold_left     = 0;
    bit tx_calm       = 1'b0;   // calm stretches: no idling at all
    bit rx_calm       = 1'b0;

    delimited_byte_list_parser u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_code  (i_char_code),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_byte_value (o_byte_value),
        .o_field_index(o_field_index),
        .o_list_end   (o_list_end),
        .o_status     (o_status)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------

    // Digit value in the current radix, -1 when not a digit
    function automatic int digit_value(input logic [7:0] c);
        int d;
        d = -1;
        if (cfg_radix == RADIX_BIN) begin
            if (c == CH_0 || c == CH_1) d = int'(c - CH_0);
        end else begin
            if (c >= CH_0 && c <= CH_9) begin
                d = int'(c - CH_0);
            end else if (cfg_radix == RADIX_HEX) begin
                if (c >= CH_LA && c <= CH_LF_) d = int'(c - CH_LA) + 10;
                else if (c >= CH_UA && c <= CH_UF) d = int'(c - CH_UA) + 10;
            end
        end
        return d;
    endfunction

    task automatic clear_list();
        acc      = '0;
        ndigits  = 0;
        nfields  = '0;
        held_err = ST_OK;
    endtask

    // Advance the list state by one accepted character; queue any field it emits
    task automatic parse_char(input logic [7:0] c);
        t_parsed_field fld;
        logic          term;
        int            d;
        int            lim;
        int            base;
        int            total;
        int            sum;
        term  = (c == CH_NUL) || (c == CH_LF);
        lim   = (cfg_radix == RADIX_BIN) ? 1 : ((cfg_radix == RADIX_HEX) ? 2 : 3);
        base  = (cfg_radix == RADIX_BIN) ? 2 : ((cfg_radix == RADIX_HEX) ? 16 : 10);
        d     = digit_value(c);
        total = int'(nfields) + 1;
        fld.byte_value  = '0;
        fld.field_index = nfields;
        fld.list_end    = 1'b1;
        fld.status      = ST_OK;
        if (held_err != ST_OK) begin
            // swallow everything up to the terminator, then report first error
            if (term) begin
                fld.status = held_err;
                expected_fields.push_back(fld);
                clear_list();
            end
        end else if (d >= 0) begin
            if (ndigits >= lim) begin
                held_err = ST_TOO_MANY_DIGITS;
            end else begin
                ndigits++;
                sum = int'(acc) * base + d;
                acc = sum[9:0];
            end
        end else if (c == cfg_delim) begin
            // delimiter beats the terminator when they coincide
            if (ndigits == 0) held_err = ST_EMPTY;
            else if (acc > BYTE_MAX) held_err = ST_OVER;
            else if (total >= int'(cfg_count)) held_err = ST_TOO_MANY_FIELDS;
            else begin
                fld.byte_value = acc[7:0];
                fld.list_end   = 1'b0;
                expected_fields.push_back(fld);
                nfields = nfields + 8'd1;
                acc     = '0;
                ndigits = 0;
            end
        end else if (term) begin
            if (ndigits == 0) fld.status = ST_EMPTY;
            else if (acc > BYTE_MAX) fld.status = ST_OVER;
            else if (total < int'(cfg_count)) fld.status = ST_TOO_FEW_FIELDS;
            else if (total > int'(cfg_count)) fld.status = ST_TOO_MANY_FIELDS;
            else fld.byte_value = acc[7:0];
            expected_fields.push_back(fld);
            clear_list();
        end else begin
            held_err = ST_BAD_CHAR;
        end
    endtask

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------

    task automatic push_char(input logic [7:0] c);
        char_queue.push_back(c);
        chars_pushed++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input int d);
        logic [7:0] c;
        if (d < 10) c = CH_0 + 8'(d);
        else if ($urandom_range(0, 1)) c = CH_UA + 8'(d - 10);
        else c = CH_LA + 8'(d - 10);
        return c;
    endfunction

    // Write v in the current radix; decimal may carry leading zeros
    task automatic push_field(input int v);
        int ndig;
        int k;
        int p;
        case (cfg_radix)
            RADIX_BIN: push_char(v[0] ? CH_1 : CH_0);
            RADIX_HEX: begin
                if (v < 16 && $urandom_range(0, 1)) begin
                    push_char(hex_char(v));
                end else begin
                    push_char(hex_char((v / 16) % 16));
                    push_char(hex_char(v % 16));
                end
            end
            default: begin
                ndig = (v >= 100) ? 3 : ((v >= 10) ? 2 : 1);
                ndig = $urandom_range(ndig, 3);
                for (k = ndig - 1; k >= 0; k--) begin
                    p = (k == 2) ? 100 : ((k == 1) ? 10 : 1);
                    push_char(CH_0 + 8'((v / p) % 10));
                end
            end
        endcase
    endtask

    // Terminator that cannot be taken for the delimiter
    task automatic push_term();
        logic [7:0] t;
        t = $urandom_range(0, 1) ? CH_LF : CH_NUL;
        if (t == cfg_delim) t = (t == CH_LF) ? CH_NUL : CH_LF;
        push_char(t);
    endtask

    // A list of n fields; when broken, one field gets a flaw
    task automatic make_list(input int n, input bit broken);
        int i;
        int v;
        int bad_at;
        int kind;
        bad_at = $urandom_range(0, n - 1);
        kind   = $urandom_range(0, 4);
        for (i = 0; i < n; i++) begin
            if (i > 0) push_char(cfg_delim);
            if (!(broken && i == bad_at && kind == 0)) begin
                v = (cfg_radix == RADIX_BIN) ? $urandom_range(0, 1) : $urandom_range(0, 255);
                if (broken && i == bad_at && kind == 1 &&
                    cfg_radix != RADIX_BIN && cfg_radix != RADIX_HEX)
                    v = $urandom_range(256, 999);
                push_field(v);
            end
            if (broken && i == bad_at) begin
                case (kind)
                    2: push_char(CH_1);                         // one digit too many
                    3: push_char(8'($urandom_range(0, 255)));   // anything at all
                    4: push_char(8'h7A);                        // letter outside hex
                    default: ;
                endcase
            end
        end
        push_term();
    endtask

    task automatic random_lists(input int budget);
        int start;
        int r;
        int n;
        int k;
        start = chars_pushed;
        while (chars_pushed - start < budget) begin
            if (cfg_count >= 1 && cfg_count <= 16) begin
                n = int'(cfg_count);
                if ($urandom_range(0, 4) == 0) n = $urandom_range(0, 1) ? n + 1 : n - 1;
                if (n < 1) n = 1;
            end else begin
                n = $urandom_range(1, 8);
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                make_list(n, 1'b0);
            end else if (r < 90) begin
                make_list(n, 1'b1);
            end else begin
                for (k = $urandom_range(1, 6); k > 0; k--)
                    push_char(8'($urandom_range(0, 255)));
                push_term();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration and phase control
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_DELIM: cfg_delim = data;
            CFG_RADIX: cfg_radix = data[1:0];
            CFG_COUNT: cfg_count = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] delim, input logic [1:0] radix,
                              input logic [7:0] count);
        write_reg(CFG_DELIM, delim);
        write_reg(CFG_RADIX, {6'd0, radix});
        write_reg(CFG_COUNT, count);
    endtask

    // Drained: nothing queued, nothing offered, nothing owed; then let the
    // pipeline settle since swallowed characters leave no trace
    task automatic wait_idle();
        do @(posedge i_clk);
        while (char_queue.size() != 0 || i_in_valid || expected_fields.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Character driver: next transaction once the current one has gone
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) tx_calm = ~tx_calm;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || char_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (char_queue.size() != 0) begin
                i_char_code <= char_queue.pop_front();
                i_in_valid  <= 1'b1;
                tx_gap = pick_gap(tx_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus the long hold-off on request
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) rx_calm = ~rx_calm;
        if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            rx_gap = pick_gap(rx_calm);
        end
    end

    // Monitor: check result transactions, predict from char transactions
    always @(posedge i_clk) begin
        char_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_fields.size() == 0) begin
                    $display("%0t: unexpected field value=%0d index=%0d end=%0b status=%0d",
                             $time, o_byte_value, o_field_index, o_list_end, o_status);
                    mismatches++;
                end else begin
                    head_field = expected_fields.pop_front();
                    if (o_byte_value !== head_field.byte_value) begin
                        $display("%0t: byte_value expected %0d actual %0d",
                                 $time, head_field.byte_value, o_byte_value);
                        mismatches++;
                    end
                    if (o_field_index !== head_field.field_index) begin
                        $display("%0t: field_index expected %0d actual %0d",
                                 $time, head_field.field_index, o_field_index);
                        mismatches++;
                    end
                    if (o_list_end !== head_field.list_end) begin
                        $display("%0t: list_end expected %0b actual %0b",
                                 $time, head_field.list_end, o_list_end);
                        mismatches++;
                    end
                    if (o_status !== head_field.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, head_field.status, o_status);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                char_taken = 1'b1;
                parse_char(i_char_code);
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < LIMIT_CYCLES; cycles++) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int p;
        int r;
        logic [7:0] delim;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: comma, decimal, one field
        push_text("255");  push_char(CH_LF);    // largest value, ok
        push_text("256");  push_char(CH_NUL);   // over 255
        push_text("1234"); push_char(CH_LF);    // too many digits
        push_text(",");    push_char(CH_LF);    // empty field at delimiter
        push_text("1x5,"); push_char(CH_LF);    // bad char, rest swallowed
        push_char(CH_LF);                       // empty list
        push_text("1,2");  push_char(CH_LF);    // too many fields
        random_lists(60);
        wait_idle();

        // Hex, mixed case; long receiver hold-off while the sender keeps going
        set_config(8'h3B, RADIX_HEX, 8'd3);
        push_text("aF;0;9e"); push_char(CH_LF);
        push_text("1;2");     push_char(CH_NUL);  // too few fields
        random_lists(150);
        hold_requests++;
        wait_idle();

        // NUL as delimiter, so only newline ends a list; full 255-field list
        set_config(CH_NUL, RADIX_BIN, 8'd255);
        make_list(255, 1'b0);
        random_lists(50);
        wait_idle();

        // Unused radix code acts as decimal; zero count rejects everything
        set_config(8'hFF, 2'd3, 8'd0);
        push_text("7"); push_char(8'hFF); push_char(CH_LF);
        push_text("99"); push_char(CH_LF);
        random_lists(50);
        wait_idle();

        // Delimiter that is also a digit: the digit wins
        set_config(CH_0, RADIX_DEC, 8'd2);
        push_text("120"); push_char(CH_LF);
        random_lists(50);
        wait_idle();

        // Newline as delimiter: only NUL terminates
        set_config(CH_LF, RADIX_HEX, 8'd1);
        random_lists(50);
        wait_idle();

        for (p = 0; p < 3; p++) begin
            r = $urandom_range(0, 4);
            case (r)
                0: delim = 8'h2C;
                1: delim = 8'h20;
                2: delim = 8'h3A;
                3: delim = 8'h2E;
                default: delim = 8'($urandom_range(0, 255));
            endcase
            set_config(delim, 2'($urandom_range(0, 3)),
                       ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                   : 8'($urandom_range(1, 6)));
            random_lists(60);
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/dblp_pkg.sv
src/delimited_byte_list_parser.sv
src/dblp_checker.sv
tb/tb_delimited_byte_list_parser.sv
